[rtl/stereo_feedback_delay_unit_assert.svh]
// Assertion macros shared by the checker of the stereo feedback delay unit
`ifndef STEREO_FEEDBACK_DELAY_UNIT_ASSERT_SVH
`define STEREO_FEEDBACK_DELAY_UNIT_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent
`define SFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent
`define SFD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[rtl/sfd_pkg.sv]
// Shared constants, types and helper functions of the stereo feedback delay unit
package sfd_pkg;

  localparam int unsigned LINE_DEPTH    = 65536;
  localparam int unsigned SAMPLE_BITS   = 24;
  localparam int unsigned FRAC_BITS     = 8;
  localparam int unsigned IDX_BITS      = $clog2(LINE_DEPTH);
  localparam int unsigned ADDR_BITS     = IDX_BITS + 1;
  localparam int unsigned DELAY_BITS    = 24;
  localparam int unsigned OFFSET_BITS   = 24;
  localparam int unsigned FB_BITS       = 16;
  localparam int unsigned GAIN_BITS     = 17;
  localparam int unsigned RAMP_BITS     = 16;
  localparam int unsigned STEP_BITS     = 25;
  localparam int unsigned TSUM_BITS     = 26;
  localparam int unsigned CFG_DATA_BITS = 24;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned MUL_A_BITS    = 25;
  localparam int unsigned MUL_B_BITS    = 18;
  localparam int unsigned PROD_BITS     = MUL_A_BITS + MUL_B_BITS;
  localparam int unsigned SUM_BITS      = SAMPLE_BITS + 3;
  localparam int unsigned GAIN_SHIFT    = 16;

  localparam logic [DELAY_BITS-1:0] DELAY_LO = DELAY_BITS'(1 << FRAC_BITS);
  localparam logic [DELAY_BITS-1:0] DELAY_HI = DELAY_BITS'((LINE_DEPTH - 2) << FRAC_BITS);
  localparam logic [GAIN_BITS-1:0]  FB_MAX   = GAIN_BITS'(64880);
  localparam logic [GAIN_BITS-1:0]  WET_MAX  = GAIN_BITS'(65536);

  localparam logic [DELAY_BITS-1:0]  RST_CENTER = DELAY_BITS'(8601600);
  localparam logic [OFFSET_BITS-1:0] RST_OFFSET = '0;
  localparam logic [FB_BITS-1:0]     RST_FB     = FB_BITS'(13107);
  localparam logic [GAIN_BITS-1:0]   RST_WET    = GAIN_BITS'(32768);
  localparam logic [RAMP_BITS-1:0]   RST_RAMP   = RAMP_BITS'(2400);

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_FEEDBACK = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_WET      = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_RAMP     = 3'd4;

  // Divider handshake status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Saturate a widened sum to the signed sample range
  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [SUM_BITS-1:0] v
  );
    logic signed [SUM_BITS-1:0] hi;
    logic signed [SUM_BITS-1:0] lo;
    hi = SUM_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
    lo = -hi - SUM_BITS'(1);
    if (v > hi) begin
      return hi[SAMPLE_BITS-1:0];
    end else if (v < lo) begin
      return lo[SAMPLE_BITS-1:0];
    end
    return v[SAMPLE_BITS-1:0];
  endfunction

  // Clamp a delay sum to the readable span of the line
  function automatic logic [DELAY_BITS-1:0] clamp_delay(
    input logic signed [TSUM_BITS-1:0] v
  );
    if (v < $signed({2'b00, DELAY_LO})) begin
      return DELAY_LO;
    end else if (v > $signed({2'b00, DELAY_HI})) begin
      return DELAY_HI;
    end
    return v[DELAY_BITS-1:0];
  endfunction

endpackage

[rtl/stereo_feedback_delay_unit.sv]
// An accepted frame is worked through by the sequencer, which walks both channels through one
// shared multiplier and the single read port of the line memory (two reads per channel); a new
// frame is not taken until the previous one has been written to the output register.
// A write to registers 0..3 that starts a glide runs four serial divides, one per glide step.
// Reset is asynchronous and active low; the lines read as silence until first written, with no
// clearing pass, and the block runs at its default setting until the first write.
module stereo_feedback_delay_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [sfd_pkg::SAMPLE_BITS-1:0] left_in_i,
  input  logic signed [sfd_pkg::SAMPLE_BITS-1:0] right_in_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [sfd_pkg::SAMPLE_BITS-1:0] left_out_o,
  output logic signed [sfd_pkg::SAMPLE_BITS-1:0] right_out_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [sfd_pkg::CFG_IDX_BITS-1:0]       cfg_index_i,
  input  logic [sfd_pkg::CFG_DATA_BITS-1:0]      cfg_data_i
);

  localparam int unsigned SB = sfd_pkg::SAMPLE_BITS;
  localparam int unsigned IB = sfd_pkg::IDX_BITS;
  localparam int unsigned DB = sfd_pkg::DELAY_BITS;
  localparam int unsigned GB = sfd_pkg::GAIN_BITS;
  localparam int unsigned TB = sfd_pkg::TSUM_BITS;
  localparam int unsigned PB = sfd_pkg::PROD_BITS;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CFG_APPLY, ST_DIV_GO, ST_DIV_WAIT, ST_GLIDE, ST_RD0, ST_RD1,
    ST_MUL_I, ST_ECHO, ST_MUL_F, ST_MUL_W, ST_OUT, ST_DONE
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [DB-1:0]                      center_q;
  logic [sfd_pkg::OFFSET_BITS-1:0]    offset_q;
  logic [sfd_pkg::FB_BITS-1:0]        fb_q;
  logic [GB-1:0]                      wet_q;
  logic [sfd_pkg::RAMP_BITS-1:0]      ramp_q;
  logic                               apply_q;

  // Glide state
  logic                               seen_q;
  logic [DB-1:0]                      tgt_delay_q [2];
  logic [GB-1:0]                      tgt_gain_q  [2];
  logic [DB-1:0]                      now_delay_q [2];
  logic [GB-1:0]                      now_gain_q  [2];
  logic signed [sfd_pkg::STEP_BITS-1:0] step_q [4];
  logic [sfd_pkg::RAMP_BITS-1:0]      left_q;
  logic [1:0]                         k_q;

  // Frame datapath
  logic                               ch_q;
  logic signed [SB-1:0]               x_q [2];
  logic signed [SB-1:0]               newer_q;
  logic signed [SB-1:0]               echo_q;
  logic signed [SB-1:0]               y_q [2];
  logic signed [PB-1:0]               prod_q;
  logic                               rd_ok_q;
  logic [IB-1:0]                      wp_q;
  logic                               wrapped_q;
  logic signed [SB-1:0]               out_left_q;
  logic signed [SB-1:0]               out_right_q;
  logic                               out_valid_q;

  // Combinational helpers
  logic signed [TB-1:0]               half;
  logic signed [TB-1:0]               left_sum;
  logic signed [TB-1:0]               right_sum;
  logic [DB-1:0]                      new_delay [2];
  logic [GB-1:0]                      new_fb;
  logic [GB-1:0]                      new_wet;
  logic signed [sfd_pkg::STEP_BITS-1:0] div_num;
  logic signed [sfd_pkg::STEP_BITS-1:0] div_quot;
  sfd_pkg::div_stat_t                 div_stat;
  logic [IB-1:0]                      whole;
  logic [IB-1:0]                      at_idx;
  logic [IB-1:0]                      rd_idx;
  logic                               rd_ok;
  logic [sfd_pkg::ADDR_BITS-1:0]      raddr;
  logic [sfd_pkg::ADDR_BITS-1:0]      waddr;
  logic [SB-1:0]                      rdata;
  logic signed [SB-1:0]               rd_val;
  logic signed [sfd_pkg::MUL_A_BITS-1:0] mul_a;
  logic signed [sfd_pkg::MUL_B_BITS-1:0] mul_b;
  logic signed [PB-1:0]               prod;
  logic signed [PB-1:0]               rnd8;
  logic signed [PB-1:0]               rnd16;
  logic signed [SB-1:0]               sat_res;
  logic                               mem_we;

  // Targets from the stored registers
  assign half      = TB'($signed(offset_q) >>> 1);
  assign left_sum  = $signed({2'b00, center_q}) - half;
  assign right_sum = $signed({2'b00, center_q}) + half;
  assign new_delay[0] = sfd_pkg::clamp_delay(left_sum);
  assign new_delay[1] = sfd_pkg::clamp_delay(right_sum);
  assign new_fb  = ({1'b0, fb_q} > sfd_pkg::FB_MAX) ? sfd_pkg::FB_MAX : {1'b0, fb_q};
  assign new_wet = (wet_q > sfd_pkg::WET_MAX) ? sfd_pkg::WET_MAX : wet_q;

  // Numerator of the glide step under division
  always_comb begin
    case (k_q)
      2'd0:    div_num = $signed({1'b0, tgt_delay_q[0]}) - $signed({1'b0, now_delay_q[0]});
      2'd1:    div_num = $signed({1'b0, tgt_delay_q[1]}) - $signed({1'b0, now_delay_q[1]});
      2'd2:    div_num = sfd_pkg::STEP_BITS'($signed({1'b0, tgt_gain_q[0]})
                         - $signed({1'b0, now_gain_q[0]}));
      default: div_num = sfd_pkg::STEP_BITS'($signed({1'b0, tgt_gain_q[1]})
                         - $signed({1'b0, now_gain_q[1]}));
    endcase
  end

  sfd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_DIV_GO),
    .num_i   (div_num),
    .den_i   (ramp_q),
    .quot_o  (div_quot),
    .stat_o  (div_stat)
  );

  // Read taps: newer slot whole frames back, older one further
  assign whole  = now_delay_q[ch_q][sfd_pkg::FRAC_BITS +: IB];
  assign at_idx = wp_q - whole;
  assign rd_idx = (state_q == ST_RD1) ? at_idx - IB'(1) : at_idx;
  assign rd_ok  = wrapped_q || (rd_idx < wp_q);
  assign raddr  = {ch_q, rd_idx};
  assign waddr  = {ch_q, wp_q};
  assign rd_val = rd_ok_q ? $signed(rdata) : '0;
  assign mem_we = (state_q == ST_MUL_W);

  // Shared multiplier operands
  always_comb begin
    case (state_q)
      ST_MUL_I: begin
        mul_a = sfd_pkg::MUL_A_BITS'(rd_val) - sfd_pkg::MUL_A_BITS'(newer_q);
        mul_b = $signed({{(sfd_pkg::MUL_B_BITS - sfd_pkg::FRAC_BITS){1'b0}},
                         now_delay_q[ch_q][sfd_pkg::FRAC_BITS-1:0]});
      end
      ST_MUL_F: begin
        mul_a = sfd_pkg::MUL_A_BITS'(echo_q);
        mul_b = $signed({1'b0, now_gain_q[0]});
      end
      ST_MUL_W: begin
        mul_a = sfd_pkg::MUL_A_BITS'(echo_q);
        mul_b = $signed({1'b0, now_gain_q[1]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign rnd8    = (prod_q + PB'(1 << (sfd_pkg::FRAC_BITS - 1))) >>> sfd_pkg::FRAC_BITS;
  assign rnd16   = (prod_q + PB'(1 << (sfd_pkg::GAIN_SHIFT - 1))) >>> sfd_pkg::GAIN_SHIFT;
  assign sat_res = sfd_pkg::sat_sample(sfd_pkg::SUM_BITS'(x_q[ch_q])
                                       + sfd_pkg::SUM_BITS'(rnd16));

  sfd_ram #(
    .AW (sfd_pkg::ADDR_BITS),
    .DW (SB)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr),
    .wdata_i (sat_res),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Sequencer: configuration, glide, per-channel echo and output beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      center_q       <= sfd_pkg::RST_CENTER;
      offset_q       <= sfd_pkg::RST_OFFSET;
      fb_q           <= sfd_pkg::RST_FB;
      wet_q          <= sfd_pkg::RST_WET;
      ramp_q         <= sfd_pkg::RST_RAMP;
      apply_q        <= 1'b0;
      seen_q         <= 1'b0;
      tgt_delay_q[0] <= sfd_pkg::RST_CENTER;
      tgt_delay_q[1] <= sfd_pkg::RST_CENTER;
      tgt_gain_q[0]  <= GB'(sfd_pkg::RST_FB);
      tgt_gain_q[1]  <= sfd_pkg::RST_WET;
      now_delay_q[0] <= sfd_pkg::RST_CENTER;
      now_delay_q[1] <= sfd_pkg::RST_CENTER;
      now_gain_q[0]  <= GB'(sfd_pkg::RST_FB);
      now_gain_q[1]  <= sfd_pkg::RST_WET;
      step_q[0]      <= '0;
      step_q[1]      <= '0;
      step_q[2]      <= '0;
      step_q[3]      <= '0;
      left_q         <= '0;
      k_q            <= '0;
      ch_q           <= 1'b0;
      x_q[0]         <= '0;
      x_q[1]         <= '0;
      newer_q        <= '0;
      echo_q         <= '0;
      y_q[0]         <= '0;
      y_q[1]         <= '0;
      prod_q         <= '0;
      rd_ok_q        <= 1'b0;
      wp_q           <= '0;
      wrapped_q      <= 1'b0;
      out_left_q     <= '0;
      out_right_q    <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      // Drop the output beat once taken, unless a new one replaces it
      if (out_valid_q && !out_stall_i && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end
      rd_ok_q <= rd_ok;
      case (state_q)
        ST_IDLE: begin
          if (cfg_valid_i) begin
            apply_q <= (cfg_index_i <= sfd_pkg::REG_WET);
            case (cfg_index_i)
              sfd_pkg::REG_CENTER:   center_q <= cfg_data_i[DB-1:0];
              sfd_pkg::REG_OFFSET:   offset_q <= cfg_data_i[sfd_pkg::OFFSET_BITS-1:0];
              sfd_pkg::REG_FEEDBACK: fb_q     <= cfg_data_i[sfd_pkg::FB_BITS-1:0];
              sfd_pkg::REG_WET:      wet_q    <= cfg_data_i[GB-1:0];
              sfd_pkg::REG_RAMP:     ramp_q   <= cfg_data_i[sfd_pkg::RAMP_BITS-1:0];
              default: begin
              end
            endcase
            state_q <= ST_CFG_APPLY;
          end else if (in_valid_i) begin
            x_q[0]  <= left_in_i;
            x_q[1]  <= right_in_i;
            state_q <= ST_GLIDE;
          end
        end
        ST_CFG_APPLY: begin
          // For a write to registers 0..3, land at once on the first setting or a zero ramp, else start the glide
          if (apply_q) begin
            tgt_delay_q[0] <= new_delay[0];
            tgt_delay_q[1] <= new_delay[1];
            tgt_gain_q[0]  <= new_fb;
            tgt_gain_q[1]  <= new_wet;
            seen_q         <= 1'b1;
            if (!seen_q || ramp_q == '0) begin
              now_delay_q[0] <= new_delay[0];
              now_delay_q[1] <= new_delay[1];
              now_gain_q[0]  <= new_fb;
              now_gain_q[1]  <= new_wet;
              step_q[0]      <= '0;
              step_q[1]      <= '0;
              step_q[2]      <= '0;
              step_q[3]      <= '0;
              left_q         <= '0;
              state_q        <= ST_IDLE;
            end else begin
              left_q  <= ramp_q;
              k_q     <= '0;
              state_q <= ST_DIV_GO;
            end
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_DIV_GO: begin
          state_q <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_stat.done) begin
            step_q[k_q] <= div_quot;
            if (k_q == 2'd3) begin
              state_q <= ST_IDLE;
            end else begin
              k_q     <= k_q + 2'd1;
              state_q <= ST_DIV_GO;
            end
          end
        end
        ST_GLIDE: begin
          // Advance the glide by one frame, landing on the targets at its end
          if (left_q != '0) begin
            left_q <= left_q - sfd_pkg::RAMP_BITS'(1);
            if (left_q == sfd_pkg::RAMP_BITS'(1)) begin
              now_delay_q[0] <= tgt_delay_q[0];
              now_delay_q[1] <= tgt_delay_q[1];
              now_gain_q[0]  <= tgt_gain_q[0];
              now_gain_q[1]  <= tgt_gain_q[1];
            end else begin
              now_delay_q[0] <= DB'($signed({1'b0, now_delay_q[0]}) + step_q[0]);
              now_delay_q[1] <= DB'($signed({1'b0, now_delay_q[1]}) + step_q[1]);
              now_gain_q[0]  <= GB'(sfd_pkg::STEP_BITS'($signed({1'b0, now_gain_q[0]}))
                                    + step_q[2]);
              now_gain_q[1]  <= GB'(sfd_pkg::STEP_BITS'($signed({1'b0, now_gain_q[1]}))
                                    + step_q[3]);
            end
          end
          ch_q    <= 1'b0;
          state_q <= ST_RD0;
        end
        ST_RD0: begin
          state_q <= ST_RD1;
        end
        ST_RD1: begin
          newer_q <= rd_val;
          state_q <= ST_MUL_I;
        end
        ST_MUL_I: begin
          prod_q  <= prod;
          state_q <= ST_ECHO;
        end
        ST_ECHO: begin
          echo_q  <= SB'(sfd_pkg::MUL_A_BITS'(newer_q) + sfd_pkg::MUL_A_BITS'(rnd8));
          state_q <= ST_MUL_F;
        end
        ST_MUL_F: begin
          prod_q  <= prod;
          state_q <= ST_MUL_W;
        end
        ST_MUL_W: begin
          // Line write happens this cycle; start the wet product
          prod_q  <= prod;
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          y_q[ch_q] <= sat_res;
          if (!ch_q) begin
            ch_q    <= 1'b1;
            state_q <= ST_RD0;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          // Hold until the output register is free
          if (!out_valid_q || !out_stall_i) begin
            out_left_q  <= y_q[0];
            out_right_q <= y_q[1];
            out_valid_q <= 1'b1;
            wp_q        <= wp_q + IB'(1);
            if (wp_q == '1) begin
              wrapped_q <= 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE) || cfg_valid_i;
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign left_out_o  = out_left_q;
  assign right_out_o = out_right_q;

endmodule

[rtl/sfd_ram.sv]
// Single-port-write, single-port-read memory with registered read data
module sfd_ram #(
  parameter int unsigned AW = 17,
  parameter int unsigned DW = 24
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [(1 << AW)];
  logic [DW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/sfd_div.sv]
// Bit-serial signed-by-unsigned divider, truncating toward zero
module sfd_div (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [sfd_pkg::STEP_BITS-1:0]  num_i,
  input  logic [sfd_pkg::RAMP_BITS-1:0]         den_i,
  output logic signed [sfd_pkg::STEP_BITS-1:0]  quot_o,
  output sfd_pkg::div_stat_t                    stat_o
);

  localparam int unsigned MAG_BITS = sfd_pkg::STEP_BITS - 1;
  localparam int unsigned CNT_BITS = $clog2(MAG_BITS + 1);

  logic [MAG_BITS-1:0]           quo_q;
  logic [sfd_pkg::RAMP_BITS-1:0] rem_q;
  logic [sfd_pkg::RAMP_BITS-1:0] den_q;
  logic [CNT_BITS-1:0]           cnt_q;
  logic                          neg_q;
  logic                          busy_q;
  logic                          done_q;
  logic [sfd_pkg::RAMP_BITS:0]   shifted;
  logic [sfd_pkg::RAMP_BITS:0]   trial;
  logic [sfd_pkg::STEP_BITS-1:0] mag;

  // Magnitude of the numerator
  assign mag = num_i[sfd_pkg::STEP_BITS-1] ? -num_i : num_i;

  // One restoring step
  assign shifted = {rem_q, quo_q[MAG_BITS-1]};
  assign trial   = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      cnt_q  <= '0;
      neg_q  <= 1'b0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        quo_q  <= mag[MAG_BITS-1:0];
        rem_q  <= '0;
        den_q  <= den_i;
        neg_q  <= num_i[sfd_pkg::STEP_BITS-1];
        cnt_q  <= CNT_BITS'(MAG_BITS);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        // Shift in one numerator bit, keep the remainder if it fits
        if (!trial[sfd_pkg::RAMP_BITS]) begin
          rem_q <= trial[sfd_pkg::RAMP_BITS-1:0];
          quo_q <= {quo_q[MAG_BITS-2:0], 1'b1};
        end else begin
          rem_q <= shifted[sfd_pkg::RAMP_BITS-1:0];
          quo_q <= {quo_q[MAG_BITS-2:0], 1'b0};
        end
        cnt_q <= cnt_q - CNT_BITS'(1);
        if (cnt_q == CNT_BITS'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign quot_o      = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

[rtl/sfd_checker.sv]
// Port-level checker of the stereo feedback delay unit, bound to the top level
`include "stereo_feedback_delay_unit_assert.svh"

module sfd_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_valid_i,
  input logic                                   in_stall_o,
  input logic                                   out_valid_o,
  input logic                                   out_stall_i,
  input logic signed [sfd_pkg::SAMPLE_BITS-1:0] left_out_o,
  input logic signed [sfd_pkg::SAMPLE_BITS-1:0] right_out_o,
  input logic                                   cfg_valid_i,
  input logic                                   cfg_ready_o
);

  // A stalled output beat stays offered
  `SFD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "output beat dropped")

  // A stalled output beat keeps its payload
  `SFD_ASSERT_NEXT(a_out_data, out_valid_o && out_stall_i,
                   $stable(left_out_o) && $stable(right_out_o), "stalled beat changed")

  // A frame in work blocks the next one
  `SFD_ASSERT_NEXT(a_in_busy, in_valid_i && !in_stall_o, in_stall_o, "frame taken while busy")

  // A register write occupies the sequencer and holds off frames and writes right after it
  `SFD_ASSERT_NEXT(a_cfg_busy, cfg_valid_i && cfg_ready_o, !cfg_ready_o && in_stall_o,
                   "sequencer free right after a write")

  // Frames are only taken when the configuration side is free too
  `SFD_ASSERT_SAME(a_in_cfg, !in_stall_o, cfg_ready_o, "frame taken during configuration")

endmodule

bind stereo_feedback_delay_unit sfd_checker u_sfd_checker (.*);
